>>> src/jnls_pkg.sv
package jnls_pkg;

  // Character classes produced by the front end.
  localparam int ClassW = 4;
  typedef logic [ClassW-1:0] class_t;

  localparam class_t CL_OTHER = 4'd0;   // nothing a literal can use
  localparam class_t CL_ZERO  = 4'd1;   // '0'
  localparam class_t CL_OCT   = 4'd2;   // '1' to '7'
  localparam class_t CL_D89   = 4'd3;   // '8' or '9'
  localparam class_t CL_DOT   = 4'd4;   // '.'
  localparam class_t CL_XCH   = 4'd5;   // 'x' or 'X'
  localparam class_t CL_ECH   = 4'd6;   // 'e' or 'E'
  localparam class_t CL_FCH   = 4'd7;   // 'f' or 'F'
  localparam class_t CL_DCH   = 4'd8;   // 'd' or 'D'
  localparam class_t CL_LCH   = 4'd9;   // 'l' or 'L'
  localparam class_t CL_HEXL  = 4'd10;  // 'a' to 'c', 'A' to 'C'

  // Scanner phases.
  localparam logic [2:0] PH_BEGIN  = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_DEC    = 3'd2;
  localparam logic [2:0] PH_OCT    = 3'd3;
  localparam logic [2:0] PH_HEX    = 3'd4;
  localparam logic [2:0] PH_FRAC   = 3'd5;
  localparam logic [2:0] PH_EXP    = 3'd6;

  // Literal kinds.
  localparam logic [1:0] K_INT    = 2'd0;
  localparam logic [1:0] K_LONG   = 2'd1;
  localparam logic [1:0] K_FLOAT  = 2'd2;
  localparam logic [1:0] K_DOUBLE = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OCT  = 2'd1;
  localparam logic [1:0] ERR_HEX  = 2'd2;

  // Queue depth between front and back ends.
  localparam int QueueDepth = 2;

  // One result word.
  typedef struct packed {
    logic [1:0] error_code;
    logic [1:0] literal_kind;
    logic       done_res;
    logic       consumed;
  } res_t;

endpackage

>>> src/jnls_front.sv
module jnls_front (
  input  logic [7:0]             char_code,
  output jnls_pkg::class_t       char_class
);

  // Map one source byte onto the small set of classes the scanner cares about.
  always_comb begin
    case (char_code) inside
      8'h30:                                 char_class = jnls_pkg::CL_ZERO;
      [8'h31:8'h37]:                         char_class = jnls_pkg::CL_OCT;
      8'h38, 8'h39:                          char_class = jnls_pkg::CL_D89;
      8'h2E:                                 char_class = jnls_pkg::CL_DOT;
      8'h78, 8'h58:                          char_class = jnls_pkg::CL_XCH;
      8'h65, 8'h45:                          char_class = jnls_pkg::CL_ECH;
      8'h66, 8'h46:                          char_class = jnls_pkg::CL_FCH;
      8'h64, 8'h44:                          char_class = jnls_pkg::CL_DCH;
      8'h6C, 8'h4C:                          char_class = jnls_pkg::CL_LCH;
      [8'h61:8'h63], [8'h41:8'h43]:          char_class = jnls_pkg::CL_HEXL;
      default:                               char_class = jnls_pkg::CL_OTHER;
    endcase
  end

endmodule

>>> src/jnls_queue.sv
module jnls_queue #(
  parameter int Depth = jnls_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jnls_pkg::class_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output jnls_pkg::class_t  pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jnls_pkg::class_t entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/jnls_back.sv
module jnls_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  jnls_pkg::class_t  in_class,
  output logic              in_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jnls_pkg::res_t    out_res
);

  logic [2:0]     phase;
  logic [2:0]     phase_next;
  jnls_pkg::res_t res_next;
  logic [1:0]     kind_so_far;
  logic           is_digit;

  // Take a class whenever the output register is empty or being emptied.
  assign in_pop = in_valid && (!out_valid || out_ready);

  // Fraction and exponent phases always belong to a double literal.
  assign kind_so_far = (phase == jnls_pkg::PH_FRAC || phase == jnls_pkg::PH_EXP) ?
                       jnls_pkg::K_DOUBLE : jnls_pkg::K_INT;
  assign is_digit = (in_class == jnls_pkg::CL_ZERO || in_class == jnls_pkg::CL_OCT ||
                     in_class == jnls_pkg::CL_D89);

  // Scanner transition and result for one character class.
  always_comb begin
    phase_next            = jnls_pkg::PH_BEGIN;
    res_next.consumed     = 1'b0;
    res_next.done_res     = 1'b1;
    res_next.literal_kind = kind_so_far;
    res_next.error_code   = jnls_pkg::ERR_NONE;
    case (phase)
      jnls_pkg::PH_PREFIX, jnls_pkg::PH_OCT, jnls_pkg::PH_DEC: begin
        if (phase == jnls_pkg::PH_PREFIX && in_class == jnls_pkg::CL_XCH) begin
          phase_next = jnls_pkg::PH_HEX;
        end else if (phase == jnls_pkg::PH_DEC && is_digit) begin
          phase_next = jnls_pkg::PH_DEC;
        end else if (phase == jnls_pkg::PH_PREFIX && is_digit) begin
          phase_next = jnls_pkg::PH_OCT;
        end else if (in_class == jnls_pkg::CL_ZERO || in_class == jnls_pkg::CL_OCT) begin
          phase_next = jnls_pkg::PH_OCT;
        end else if (in_class == jnls_pkg::CL_D89) begin
          res_next.literal_kind = jnls_pkg::K_INT;
          res_next.error_code   = jnls_pkg::ERR_OCT;
        end else if (in_class == jnls_pkg::CL_DOT) begin
          phase_next = jnls_pkg::PH_FRAC;
        end else if (in_class == jnls_pkg::CL_ECH) begin
          phase_next = jnls_pkg::PH_EXP;
        end else if (in_class == jnls_pkg::CL_FCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_FLOAT;
        end else if (in_class == jnls_pkg::CL_DCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_DOUBLE;
        end else if (in_class == jnls_pkg::CL_LCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_LONG;
        end
      end
      jnls_pkg::PH_HEX: begin
        if (is_digit || in_class == jnls_pkg::CL_HEXL || in_class == jnls_pkg::CL_ECH ||
            in_class == jnls_pkg::CL_FCH || in_class == jnls_pkg::CL_DCH) begin
          phase_next = jnls_pkg::PH_HEX;
        end else if (in_class == jnls_pkg::CL_DOT) begin
          res_next.error_code = jnls_pkg::ERR_HEX;
        end else if (in_class == jnls_pkg::CL_LCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_LONG;
        end
      end
      jnls_pkg::PH_FRAC, jnls_pkg::PH_EXP: begin
        if (is_digit) begin
          phase_next = phase;
        end else if (phase == jnls_pkg::PH_FRAC && in_class == jnls_pkg::CL_ECH) begin
          phase_next = jnls_pkg::PH_EXP;
        end else if (in_class == jnls_pkg::CL_FCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_FLOAT;
        end else if (in_class == jnls_pkg::CL_DCH) begin
          res_next.consumed     = 1'b1;
          res_next.literal_kind = jnls_pkg::K_DOUBLE;
        end
      end
      default: begin
        if (in_class == jnls_pkg::CL_ZERO) begin
          phase_next = jnls_pkg::PH_PREFIX;
        end else if (is_digit) begin
          phase_next = jnls_pkg::PH_DEC;
        end else if (in_class == jnls_pkg::CL_DOT) begin
          phase_next = jnls_pkg::PH_FRAC;
        end else begin
          res_next.literal_kind = jnls_pkg::K_INT;
        end
      end
    endcase
    // Any move to a working phase consumes the character and reports nothing else.
    if (phase_next != jnls_pkg::PH_BEGIN) begin
      res_next.consumed     = 1'b1;
      res_next.done_res     = 1'b0;
      res_next.literal_kind = jnls_pkg::K_INT;
    end
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jnls_pkg::PH_BEGIN;
    end else if (in_pop) begin
      phase <= phase_next;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      out_res <= res_next;
    end
  end

  // A finished literal always sends the scanner back to its begin phase.
  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    in_pop && res_next.done_res |=> phase == jnls_pkg::PH_BEGIN)
    else $error("scanner did not restart after a finished literal");

  // An error never consumes the character and always ends the literal.
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.error_code != jnls_pkg::ERR_NONE |->
    !out_res.consumed && out_res.done_res && out_res.literal_kind == jnls_pkg::K_INT)
    else $error("error word has a bad form");

  // A word still in progress carries neither kind nor error.
  a_progress_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |->
    out_res.consumed && out_res.literal_kind == jnls_pkg::K_INT &&
    out_res.error_code == jnls_pkg::ERR_NONE)
    else $error("in-progress word has a bad form");

  // A stalled output word is held.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("output word changed while stalled");

endmodule

>>> src/java_numeric_literal_scanner_top.sv
// A word accepted on s_tdata is classified and held in the class queue; its result word is
// then registered in the output register, from which it is offered on m_tdata.
// Throughput: one character word per cycle while neither side stalls; the class queue
// (two entries by default) and the output register let either side stall for a short
// while without stopping the other. Reset (rst, synchronous, active high) empties the
// queue and the output register and puts the scanner in its begin phase.
module java_numeric_literal_scanner_top #(
  parameter int QueueDepth = jnls_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] consumed, [1] done_res, [3:2] literal_kind,
                                // [5:4] error_code, [7:6] zero
);

  jnls_pkg::class_t char_class;
  jnls_pkg::class_t queue_class;
  jnls_pkg::res_t   res;
  logic             queue_full;
  logic             queue_valid;
  logic             queue_pop;
  logic             push;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  // Front end: classify the incoming character.
  jnls_front u_front (
    .char_code  (s_tdata),
    .char_class (char_class)
  );

  // Queue of classified characters.
  jnls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (char_class),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_valid),
    .pop_data  (queue_class)
  );

  // Back end: scanner state machine and output word register.
  jnls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_valid),
    .in_class  (queue_class),
    .in_pop    (queue_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {2'b00, res};

endmodule

>>> dv/tb_java_numeric_literal_scanner_top.sv
`timescale 1ns / 1ps

module tb_java_numeric_literal_scanner_top;

  localparam int CycleLimit = 200000;
  localparam int StallCycles = 300;
  localparam int ItemsPerPhase = 550;

  // Tracks the scanner state and holds the result words still to come.
  class literal_scoreboard;
    logic [2:0] phase;
    logic [1:0] kind;
    jnls_pkg::res_t expected_res[$];
    int mismatches;
    int chars_seen;
    int kind_count[4];
    int oct_errors;
    int hex_errors;

    function new();
      phase = jnls_pkg::PH_BEGIN;
      kind = jnls_pkg::K_INT;
      mismatches = 0;
      chars_seen = 0;
      oct_errors = 0;
      hex_errors = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function jnls_pkg::res_t step_to(logic [2:0] ph);
      jnls_pkg::res_t r;
      r = '0;
      r.consumed = 1'b1;
      phase = ph;
      return r;
    endfunction

    function jnls_pkg::res_t close_literal(logic cons, logic [1:0] k, logic [1:0] err);
      jnls_pkg::res_t r;
      r = '0;
      r.consumed = cons;
      r.done_res = 1'b1;
      r.literal_kind = k;
      r.error_code = err;
      phase = jnls_pkg::PH_BEGIN;
      kind = jnls_pkg::K_INT;
      return r;
    endfunction

    // Next-state and result for one character, one result per character.
    function jnls_pkg::res_t scan_char(logic [7:0] c);
      logic dig;
      logic expc;
      logic hexc;
      dig  = (c >= "0") && (c <= "9");
      expc = (c == "e") || (c == "E");
      hexc = dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
      case (phase)
        jnls_pkg::PH_PREFIX, jnls_pkg::PH_OCT: begin
          if (phase == jnls_pkg::PH_PREFIX && (c == "x" || c == "X"))
            return step_to(jnls_pkg::PH_HEX);
          if (phase == jnls_pkg::PH_PREFIX && dig) return step_to(jnls_pkg::PH_OCT);
          if (c >= "0" && c <= "7") return step_to(jnls_pkg::PH_OCT);
          if (c == "8" || c == "9")
            return close_literal(1'b0, jnls_pkg::K_INT, jnls_pkg::ERR_OCT);
          if (c == ".") begin
            kind = jnls_pkg::K_DOUBLE;
            return step_to(jnls_pkg::PH_FRAC);
          end
          if (expc) begin
            kind = jnls_pkg::K_DOUBLE;
            return step_to(jnls_pkg::PH_EXP);
          end
          if (c == "f" || c == "F")
            return close_literal(1'b1, jnls_pkg::K_FLOAT, jnls_pkg::ERR_NONE);
          if (c == "d" || c == "D")
            return close_literal(1'b1, jnls_pkg::K_DOUBLE, jnls_pkg::ERR_NONE);
          if (c == "l" || c == "L")
            return close_literal(1'b1, jnls_pkg::K_LONG, jnls_pkg::ERR_NONE);
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
        jnls_pkg::PH_DEC: begin
          if (dig) return step_to(jnls_pkg::PH_DEC);
          if (c == ".") begin
            kind = jnls_pkg::K_DOUBLE;
            return step_to(jnls_pkg::PH_FRAC);
          end
          if (expc) begin
            kind = jnls_pkg::K_DOUBLE;
            return step_to(jnls_pkg::PH_EXP);
          end
          if (c == "f" || c == "F")
            return close_literal(1'b1, jnls_pkg::K_FLOAT, jnls_pkg::ERR_NONE);
          if (c == "d" || c == "D")
            return close_literal(1'b1, jnls_pkg::K_DOUBLE, jnls_pkg::ERR_NONE);
          if (c == "l" || c == "L")
            return close_literal(1'b1, jnls_pkg::K_LONG, jnls_pkg::ERR_NONE);
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
        jnls_pkg::PH_HEX: begin
          if (hexc) return step_to(jnls_pkg::PH_HEX);
          if (c == ".") return close_literal(1'b0, jnls_pkg::K_INT, jnls_pkg::ERR_HEX);
          if (c == "l" || c == "L")
            return close_literal(1'b1, jnls_pkg::K_LONG, jnls_pkg::ERR_NONE);
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
        jnls_pkg::PH_FRAC: begin
          if (dig) return step_to(jnls_pkg::PH_FRAC);
          if (expc) return step_to(jnls_pkg::PH_EXP);
          if (c == "f" || c == "F")
            return close_literal(1'b1, jnls_pkg::K_FLOAT, jnls_pkg::ERR_NONE);
          if (c == "d" || c == "D")
            return close_literal(1'b1, jnls_pkg::K_DOUBLE, jnls_pkg::ERR_NONE);
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
        jnls_pkg::PH_EXP: begin
          if (dig) return step_to(jnls_pkg::PH_EXP);
          if (c == "f" || c == "F")
            return close_literal(1'b1, jnls_pkg::K_FLOAT, jnls_pkg::ERR_NONE);
          if (c == "d" || c == "D")
            return close_literal(1'b1, jnls_pkg::K_DOUBLE, jnls_pkg::ERR_NONE);
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
        default: begin
          // Begin state; codes with no phase behave the same.
          kind = jnls_pkg::K_INT;
          if (c == "0") return step_to(jnls_pkg::PH_PREFIX);
          if (dig) return step_to(jnls_pkg::PH_DEC);
          if (c == ".") begin
            kind = jnls_pkg::K_DOUBLE;
            return step_to(jnls_pkg::PH_FRAC);
          end
          return close_literal(1'b0, kind, jnls_pkg::ERR_NONE);
        end
      endcase
    endfunction

    function void note_char(logic [7:0] c);
      jnls_pkg::res_t r;
      chars_seen++;
      r = scan_char(c);
      expected_res.insert(expected_res.size(), r);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_word(logic [7:0] w);
      jnls_pkg::res_t want;
      if (expected_res.size() == 0) begin
        mismatches++;
        $display("%0t ns: result word with nothing expected, expected none, actual 0x%02h",
                 $time, w);
        return;
      end
      want = expected_res.pop_front();
      compare_field("consumed", want.consumed, w[0]);
      compare_field("done_res", want.done_res, w[1]);
      compare_field("literal_kind", want.literal_kind, w[3:2]);
      compare_field("error_code", want.error_code, w[5:4]);
      compare_field("padding", 0, w[7:6]);
      if (want.done_res) begin
        if (want.error_code == jnls_pkg::ERR_OCT) oct_errors++;
        else if (want.error_code == jnls_pkg::ERR_HEX) hex_errors++;
        else kind_count[want.literal_kind]++;
      end
    endfunction

    function int outstanding();
      return expected_res.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;

  literal_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;
  int cycles = 0;
  logic [7:0] token[$];

  java_numeric_literal_scanner_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit; a hang ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Result words are checked as they are accepted.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  // Receiver ready, with random stalls and one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        stall_done = 1'b1;
        for (int k = 0; k < StallCycles; k++) begin
          m_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one character word and waits for it to be taken; enters and leaves
  // at a falling edge.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_char(c);
    @(negedge clk);
  endtask

  // Sender stops and waits until every expected result word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Appends one character to the token being built.
  function automatic void add_char(logic [7:0] c);
    token.insert(token.size(), c);
  endfunction

  function automatic logic [7:0] digit(int lo, int hi);
    return 8'("0" + $urandom_range(lo, hi));
  endfunction

  // Optional fraction and exponent, then an optional suffix.
  function automatic void add_tail(bit with_frac, bit with_long);
    if (with_frac && $urandom_range(0, 1)) begin
      add_char(".");
      repeat ($urandom_range(0, 3)) add_char(digit(0, 9));
    end
    if ($urandom_range(0, 2) == 0) begin
      add_char($urandom_range(0, 1) ? 8'("e") : 8'("E"));
      repeat ($urandom_range(0, 3)) add_char(digit(0, 9));
    end
    case ($urandom_range(0, 3))
      1: add_char($urandom_range(0, 1) ? 8'("f") : 8'("F"));
      2: add_char($urandom_range(0, 1) ? 8'("d") : 8'("D"));
      3: if (with_long) add_char($urandom_range(0, 1) ? 8'("l") : 8'("L"));
      default: ;
    endcase
  endfunction

  // Mostly well-formed literals with random content, some broken, some noise.
  function automatic void build_token();
    int shape;
    string hexset;
    string seps;
    hexset = "0123456789abcdefABCDEF";
    seps = " ;+),";
    token.delete();
    shape = $urandom_range(0, 99);
    if (shape < 10) begin
      add_char(8'($urandom_range(0, 255)));
      return;
    end
    case (shape % 5)
      0: begin
        add_char(digit(1, 9));
        repeat ($urandom_range(0, 4)) add_char(digit(0, 9));
        add_tail(1'b1, 1'b1);
      end
      1: begin
        add_char("0");
        repeat ($urandom_range(0, 4))
          add_char(($urandom_range(0, 9) == 0) ? digit(8, 9) : digit(0, 7));
        add_tail(1'b1, 1'b1);
      end
      2: begin
        add_char("0");
        add_char($urandom_range(0, 1) ? 8'("x") : 8'("X"));
        repeat ($urandom_range(0, 4)) add_char(hexset[$urandom_range(0, 21)]);
        case ($urandom_range(0, 3))
          0: add_char(".");
          1: add_char($urandom_range(0, 1) ? 8'("l") : 8'("L"));
          default: ;
        endcase
      end
      3: begin
        add_char(".");
        repeat ($urandom_range(0, 3)) add_char(digit(0, 9));
        add_tail(1'b0, 1'b0);
      end
      default: begin
        add_char("0");
        add_tail(1'b1, 1'b1);
      end
    endcase
    case ($urandom_range(0, 5))
      0: add_char(8'h00);
      1: add_char(8'($urandom_range(0, 255)));
      default: add_char(seps[$urandom_range(0, 4)]);
    endcase
  endfunction

  task automatic random_phase(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      build_token();
      foreach (token[i]) send_char(token[i]);
      sent += token.size();
    end
  endtask

  initial begin
    string directed;
    directed = "0x1F.07908l1.5e3f.2D ";
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly, receiver heavily; directed cases first.
    send_idle_pct = 12;
    recv_idle_pct = 47;
    for (int i = 0; i < directed.len(); i++) send_char(directed[i]);
    send_char(8'hFF);
    send_char(8'h00);
    random_phase(ItemsPerPhase);
    drain();

    // Roles swapped.
    send_idle_pct = 47;
    recv_idle_pct = 12;
    random_phase(ItemsPerPhase);
    drain();

    // Full rate, opened by a long receiver hold-off so the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    random_phase(ItemsPerPhase);
    drain();
    repeat (10) @(posedge clk);

    $display("Scanned %0d characters: %0d int, %0d long, %0d float, %0d double literals,",
             sb.chars_seen, sb.kind_count[jnls_pkg::K_INT], sb.kind_count[jnls_pkg::K_LONG],
             sb.kind_count[jnls_pkg::K_FLOAT], sb.kind_count[jnls_pkg::K_DOUBLE]);
    $display("%0d octal digit errors and %0d hex dot errors, %0d mismatches.",
             sb.oct_errors, sb.hex_errors, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/jnls_pkg.sv
src/jnls_front.sv
src/jnls_queue.sv
src/jnls_back.sv
src/java_numeric_literal_scanner_top.sv
dv/tb_java_numeric_literal_scanner_top.sv
